// File: rtl/lc3ie_pkg.sv
// Shared types, opcode and trap codes, and small helper functions for the LC-3 executor.
// Used by every module of the block; depends on nothing.
package lc3ie_pkg;

   localparam int MEM_WORDS_DEF = 65536;
   localparam int MAX_OUT_CHARS_DEF = 64;

   localparam logic [15:0] KBSR_ADDR = 16'hFE00;
   localparam logic [15:0] KBDR_ADDR = 16'hFE02;
   localparam logic [15:0] KB_READY_WORD = 16'h8000;

   localparam logic [2:0] FLAG_P = 3'd1;
   localparam logic [2:0] FLAG_Z = 3'd2;
   localparam logic [2:0] FLAG_N = 3'd4;

   localparam logic [1:0] OPC_LOAD = 2'd0;
   localparam logic [1:0] OPC_SETPC = 2'd1;
   localparam logic [1:0] OPC_EXEC = 2'd2;

   localparam logic [3:0] OP_BR = 4'd0;
   localparam logic [3:0] OP_ADD = 4'd1;
   localparam logic [3:0] OP_LD = 4'd2;
   localparam logic [3:0] OP_ST = 4'd3;
   localparam logic [3:0] OP_JSR = 4'd4;
   localparam logic [3:0] OP_AND = 4'd5;
   localparam logic [3:0] OP_LDR = 4'd6;
   localparam logic [3:0] OP_STR = 4'd7;
   localparam logic [3:0] OP_NOT = 4'd9;
   localparam logic [3:0] OP_LDI = 4'd10;
   localparam logic [3:0] OP_STI = 4'd11;
   localparam logic [3:0] OP_JMP = 4'd12;
   localparam logic [3:0] OP_LEA = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   localparam logic [7:0] TRAP_GETC = 8'h20;
   localparam logic [7:0] TRAP_OUT = 8'h21;
   localparam logic [7:0] TRAP_PUTS = 8'h22;
   localparam logic [7:0] TRAP_IN = 8'h23;
   localparam logic [7:0] TRAP_PUTSP = 8'h24;
   localparam logic [7:0] TRAP_HALT = 8'h25;

   localparam logic [7:0] PROMPT_CHAR = 8'h3E;

   typedef struct packed {
      logic [1:0] op;
      logic [15:0] address;
      logic [15:0] data;
      logic key_ready;
      logic [7:0] key_code;
   } req_word_type;

   typedef struct packed {
      logic out_valid;
      logic [7:0] out_char;
      logic last;
      logic halted;
      logic [15:0] pc_now;
      logic truncated;
   } rsp_word_type;

   typedef enum logic [3:0] {
      KIND_LOAD = 4'b0001,
      KIND_SETPC = 4'b0010,
      KIND_EXEC = 4'b0100,
      KIND_NOP = 4'b1000
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [15:0] address;
      logic [15:0] data;
      logic key_ready;
      logic [7:0] key_code;
   } item_type;

   typedef struct packed {
      logic valid;
      logic [7:0] ch;
   } push_type;

   typedef struct packed {
      logic valid;
      logic halted;
      logic [15:0] pc;
      logic trunc;
   } fin_type;

   function automatic logic [15:0] sext5(input logic [4:0] v);
      return {{11{v[4]}}, v};
   endfunction

   function automatic logic [15:0] sext6(input logic [5:0] v);
      return {{10{v[5]}}, v};
   endfunction

   function automatic logic [15:0] sext9(input logic [8:0] v);
      return {{7{v[8]}}, v};
   endfunction

   function automatic logic [15:0] sext11(input logic [10:0] v);
      return {{5{v[10]}}, v};
   endfunction

   function automatic logic [2:0] flags_of(input logic [15:0] v);
      logic [2:0] f;
      if (v == 16'd0) begin
         f = FLAG_Z;
      end else if (v[15]) begin
         f = FLAG_N;
      end else begin
         f = FLAG_P;
      end
      return f;
   endfunction

endpackage

// File: rtl/lc3ie_front.sv
// Front end: accepts request words, classifies them and holds them in a two-entry queue.
// Depends on lc3ie_pkg.
module lc3ie_front (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  lc3ie_pkg::req_word_type req_word,
   output logic q_valid,
   output lc3ie_pkg::item_type q_item,
   input  logic pop
);

   lc3ie_pkg::item_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic accept;
   lc3ie_pkg::item_type cls;

   assign busy = (cnt_ff == 2'd2);
   assign accept = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = slot_ff[rd_ptr_ff];

   always_comb begin
      cls.address = req_word.address;
      cls.data = req_word.data;
      cls.key_ready = req_word.key_ready;
      cls.key_code = req_word.key_code;
      unique case (req_word.op)
         lc3ie_pkg::OPC_LOAD: cls.kind = lc3ie_pkg::KIND_LOAD;
         lc3ie_pkg::OPC_SETPC: cls.kind = lc3ie_pkg::KIND_SETPC;
         lc3ie_pkg::OPC_EXEC: cls.kind = lc3ie_pkg::KIND_EXEC;
         default: cls.kind = lc3ie_pkg::KIND_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + {1'b0, accept} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset) pop |-> cnt_ff != 2'd0)
      else $error("pop from empty queue");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count did not grow on push");
`endif

endmodule

// File: rtl/lc3ie_exec.sv
// Back end: LC-3 execution engine with word memory, register file, PC, flags and halt mark.
// Depends on lc3ie_pkg; feeds characters and completion status to lc3ie_emit.
module lc3ie_exec #(
   parameter int MEM_WORDS = lc3ie_pkg::MEM_WORDS_DEF,
   parameter int MAX_OUT_CHARS = lc3ie_pkg::MAX_OUT_CHARS_DEF,
   localparam int AW = $clog2(MEM_WORDS),
   localparam int IW = $clog2(MAX_OUT_CHARS),
   localparam int CW = $clog2(MAX_OUT_CHARS + 1)
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   input  lc3ie_pkg::item_type q_item,
   output logic pop,
   input  logic emit_busy,
   output lc3ie_pkg::push_type push,
   output logic [IW-1:0] push_idx,
   output lc3ie_pkg::fin_type fin,
   output logic [CW-1:0] fin_count
);

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_RD = 10'b0000000010,
      S_RDKB = 10'b0000000100,
      S_RDW = 10'b0000001000,
      S_DATA = 10'b0000010000,
      S_EXE = 10'b0000100000,
      S_WR = 10'b0001000000,
      S_TRAP2 = 10'b0010000000,
      S_STRHI = 10'b0100000000,
      S_FIN = 10'b1000000000
   } state_type;

   typedef enum logic [4:0] {
      PH_FETCH = 5'b00001,
      PH_LOAD = 5'b00010,
      PH_LDI = 5'b00100,
      PH_STI = 5'b01000,
      PH_STR = 5'b10000
   } phase_type;

   localparam logic [19:0] MW20 = 20'(MEM_WORDS);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_OUT_CHARS);

   // Folds a 16-bit address into the memory; the quotient is below 16.
   function automatic logic [AW-1:0] mem_index(input logic [15:0] a);
      logic [19:0] v;
      v = {4'd0, a};
      for (int k = 3; k >= 0; k--) begin
         if (v >= (MW20 << k)) begin
            v = v - (MW20 << k);
         end
      end
      return v[AW-1:0];
   endfunction

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   lc3ie_pkg::item_type cur_ff, cur_in;
   logic [15:0] ins_ff, ins_in;
   logic [15:0] pc_ff, pc_in;
   logic [2:0] flags_ff, flags_in;
   logic halt_ff, halt_in;
   logic [15:0] opa_ff, opa_in;
   logic [15:0] opb_ff, opb_in;
   logic [15:0] rd_addr_ff, rd_addr_in;
   logic [15:0] wr_addr_ff, wr_addr_in;
   logic [15:0] rdata_ff, rdata_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic trunc_ff, trunc_in;

   logic [15:0] gpr_ff [8];
   logic gw_en;
   logic [2:0] gw_addr;
   logic [15:0] gw_data;

   logic [15:0] mem [MEM_WORDS];
   logic [15:0] mem_q;
   logic mem_we;
   logic [15:0] mem_wa;
   logic [15:0] mem_wd;

   logic [3:0] opcode;
   logic [2:0] dr;
   logic [15:0] pcoff9;
   logic [15:0] opnd;
   logic [3:0] fop;
   logic [2:0] ra, rb;
   logic [7:0] lo_c, hi_c;

   assign opcode = ins_ff[15:12];
   assign dr = ins_ff[11:9];
   assign pcoff9 = pc_ff + lc3ie_pkg::sext9(ins_ff[8:0]);
   assign opnd = ins_ff[5] ? lc3ie_pkg::sext5(ins_ff[4:0]) : opb_ff;
   assign fop = rdata_ff[15:12];
   assign lo_c = rdata_ff[7:0];
   assign hi_c = rdata_ff[15:8];

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cur_in = cur_ff;
      ins_in = ins_ff;
      pc_in = pc_ff;
      flags_in = flags_ff;
      halt_in = halt_ff;
      opa_in = opa_ff;
      opb_in = opb_ff;
      rd_addr_in = rd_addr_ff;
      wr_addr_in = wr_addr_ff;
      rdata_in = rdata_ff;
      cnt_in = cnt_ff;
      trunc_in = trunc_ff;
      gw_en = 1'b0;
      gw_addr = 3'd0;
      gw_data = 16'd0;
      mem_we = 1'b0;
      mem_wa = 16'd0;
      mem_wd = 16'd0;
      pop = 1'b0;
      push = '0;
      push_idx = cnt_ff[IW-1:0];
      fin = '0;
      fin_count = cnt_ff;
      ra = (fop == lc3ie_pkg::OP_TRAP) ? 3'd0 : rdata_ff[8:6];
      rb = (fop == lc3ie_pkg::OP_ST || fop == lc3ie_pkg::OP_STR || fop == lc3ie_pkg::OP_STI)
         ? rdata_ff[11:9] : rdata_ff[2:0];

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && !emit_busy) begin
               pop = 1'b1;
               cur_in = q_item;
               cnt_in = '0;
               trunc_in = 1'b0;
               state_in = S_FIN;
               unique case (q_item.kind)
                  lc3ie_pkg::KIND_LOAD: begin
                     mem_we = 1'b1;
                     mem_wa = q_item.address;
                     mem_wd = q_item.data;
                  end
                  lc3ie_pkg::KIND_SETPC: begin
                     pc_in = q_item.address;
                     halt_in = 1'b0;
                  end
                  lc3ie_pkg::KIND_EXEC: begin
                     if (!halt_ff) begin
                        rd_addr_in = pc_ff;
                        phase_in = PH_FETCH;
                        state_in = S_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD: begin
            if (rd_addr_ff == lc3ie_pkg::KBSR_ADDR) begin
               // A status read refreshes the keyboard registers first.
               mem_we = 1'b1;
               mem_wa = lc3ie_pkg::KBSR_ADDR;
               mem_wd = cur_ff.key_ready ? lc3ie_pkg::KB_READY_WORD : 16'd0;
               rdata_in = mem_wd;
               state_in = S_RDKB;
            end else begin
               state_in = S_RDW;
            end
         end
         S_RDKB: begin
            if (cur_ff.key_ready) begin
               mem_we = 1'b1;
               mem_wa = lc3ie_pkg::KBDR_ADDR;
               mem_wd = {8'd0, cur_ff.key_code};
            end
            state_in = S_DATA;
         end
         S_RDW: begin
            rdata_in = mem_q;
            state_in = S_DATA;
         end
         S_DATA: begin
            state_in = S_FIN;
            unique case (phase_ff)
               PH_FETCH: begin
                  ins_in = rdata_ff;
                  pc_in = pc_ff + 16'd1;
                  opa_in = gpr_ff[ra];
                  opb_in = gpr_ff[rb];
                  state_in = S_EXE;
               end
               PH_LOAD: begin
                  gw_en = 1'b1;
                  gw_addr = dr;
                  gw_data = rdata_ff;
                  flags_in = lc3ie_pkg::flags_of(rdata_ff);
               end
               PH_LDI: begin
                  rd_addr_in = rdata_ff;
                  phase_in = PH_LOAD;
                  state_in = S_RD;
               end
               PH_STI: begin
                  wr_addr_in = rdata_ff;
                  state_in = S_WR;
               end
               default: begin
                  if (lo_c == 8'd0) begin
                     state_in = S_FIN;
                  end else if (cnt_ff == CNT_MAX) begin
                     trunc_in = 1'b1;
                  end else begin
                     push.valid = 1'b1;
                     push.ch = lo_c;
                     cnt_in = cnt_ff + CW'(1);
                     if (ins_ff[7:0] == lc3ie_pkg::TRAP_PUTSP) begin
                        state_in = S_STRHI;
                     end else begin
                        rd_addr_in = rd_addr_ff + 16'd1;
                        state_in = S_RD;
                     end
                  end
               end
            endcase
         end
         S_EXE: begin
            state_in = S_FIN;
            unique case (opcode) inside
               lc3ie_pkg::OP_BR: begin
                  if ((dr & flags_ff) != 3'd0) begin
                     pc_in = pcoff9;
                  end
               end
               lc3ie_pkg::OP_ADD, lc3ie_pkg::OP_AND, lc3ie_pkg::OP_NOT,
               lc3ie_pkg::OP_LEA: begin
                  gw_en = 1'b1;
                  gw_addr = dr;
                  if (opcode == lc3ie_pkg::OP_ADD) begin
                     gw_data = opa_ff + opnd;
                  end else if (opcode == lc3ie_pkg::OP_AND) begin
                     gw_data = opa_ff & opnd;
                  end else if (opcode == lc3ie_pkg::OP_NOT) begin
                     gw_data = ~opa_ff;
                  end else begin
                     gw_data = pcoff9;
                  end
                  flags_in = lc3ie_pkg::flags_of(gw_data);
               end
               lc3ie_pkg::OP_LD: begin
                  rd_addr_in = pcoff9;
                  phase_in = PH_LOAD;
                  state_in = S_RD;
               end
               lc3ie_pkg::OP_LDR: begin
                  rd_addr_in = opa_ff + lc3ie_pkg::sext6(ins_ff[5:0]);
                  phase_in = PH_LOAD;
                  state_in = S_RD;
               end
               lc3ie_pkg::OP_LDI: begin
                  rd_addr_in = pcoff9;
                  phase_in = PH_LDI;
                  state_in = S_RD;
               end
               lc3ie_pkg::OP_STI: begin
                  rd_addr_in = pcoff9;
                  phase_in = PH_STI;
                  state_in = S_RD;
               end
               lc3ie_pkg::OP_ST: begin
                  wr_addr_in = pcoff9;
                  state_in = S_WR;
               end
               lc3ie_pkg::OP_STR: begin
                  wr_addr_in = opa_ff + lc3ie_pkg::sext6(ins_ff[5:0]);
                  state_in = S_WR;
               end
               lc3ie_pkg::OP_JSR: begin
                  pc_in = ins_ff[11] ? pc_ff + lc3ie_pkg::sext11(ins_ff[10:0]) : opa_ff;
                  gw_en = 1'b1;
                  gw_addr = 3'd7;
                  gw_data = pc_ff;
               end
               lc3ie_pkg::OP_JMP: begin
                  pc_in = opa_ff;
               end
               lc3ie_pkg::OP_TRAP: begin
                  gw_en = 1'b1;
                  gw_addr = 3'd7;
                  gw_data = pc_ff;
                  unique case (ins_ff[7:0]) inside
                     lc3ie_pkg::TRAP_GETC: state_in = S_TRAP2;
                     lc3ie_pkg::TRAP_OUT: begin
                        push.valid = 1'b1;
                        push.ch = opa_ff[7:0];
                        cnt_in = cnt_ff + CW'(1);
                     end
                     lc3ie_pkg::TRAP_PUTS, lc3ie_pkg::TRAP_PUTSP: begin
                        rd_addr_in = opa_ff;
                        phase_in = PH_STR;
                        state_in = S_RD;
                     end
                     lc3ie_pkg::TRAP_IN: begin
                        push.valid = 1'b1;
                        push.ch = lc3ie_pkg::PROMPT_CHAR;
                        cnt_in = cnt_ff + CW'(1);
                        state_in = S_TRAP2;
                     end
                     lc3ie_pkg::TRAP_HALT: halt_in = 1'b1;
                     default: begin
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
         S_WR: begin
            mem_we = 1'b1;
            mem_wa = wr_addr_ff;
            mem_wd = opb_ff;
            state_in = S_FIN;
         end
         S_TRAP2: begin
            gw_en = 1'b1;
            gw_addr = 3'd0;
            gw_data = {8'd0, cur_ff.key_code};
            flags_in = lc3ie_pkg::flags_of(gw_data);
            if (ins_ff[7:0] == lc3ie_pkg::TRAP_IN) begin
               push.valid = 1'b1;
               push.ch = cur_ff.key_code;
               cnt_in = cnt_ff + CW'(1);
            end
            state_in = S_FIN;
         end
         S_STRHI: begin
            state_in = S_FIN;
            if (hi_c != 8'd0) begin
               if (cnt_ff == CNT_MAX) begin
                  trunc_in = 1'b1;
               end else begin
                  push.valid = 1'b1;
                  push.ch = hi_c;
                  cnt_in = cnt_ff + CW'(1);
                  rd_addr_in = rd_addr_ff + 16'd1;
                  state_in = S_RD;
               end
            end
         end
         S_FIN: begin
            fin.valid = 1'b1;
            fin.halted = halt_ff;
            fin.pc = pc_ff;
            fin.trunc = trunc_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_FETCH;
         pc_ff <= 16'd0;
         flags_ff <= 3'd0;
         halt_ff <= 1'b0;
         cnt_ff <= '0;
         trunc_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         pc_ff <= pc_in;
         flags_ff <= flags_in;
         halt_ff <= halt_in;
         cnt_ff <= cnt_in;
         trunc_ff <= trunc_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      ins_ff <= ins_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      rd_addr_ff <= rd_addr_in;
      wr_addr_ff <= wr_addr_in;
      rdata_ff <= rdata_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            gpr_ff[i] <= 16'd0;
         end
      end else if (gw_en) begin
         gpr_ff[gw_addr] <= gw_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_index(mem_wa)] <= mem_wd;
      end
      mem_q <= mem[mem_index(rd_addr_ff)];
   end

`ifndef SYNTHESIS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> cnt_ff < CNT_MAX)
      else $error("character pushed past the bound");
   a_trunc_full: assert property (@(posedge clock) disable iff (reset)
      trunc_ff |-> cnt_ff == CNT_MAX)
      else $error("truncation flagged with room left");
   a_halted_skip: assert property (@(posedge clock) disable iff (reset)
      pop && q_item.kind == lc3ie_pkg::KIND_EXEC && halt_ff |=> state_ff == S_FIN)
      else $error("instruction executed while halted");
`endif

endmodule

// File: rtl/lc3ie_emit.sv
// Result stage: buffers the characters of one word and streams them out as results.
// Depends on lc3ie_pkg; fed by lc3ie_exec.
module lc3ie_emit #(
   parameter int MAX_OUT_CHARS = lc3ie_pkg::MAX_OUT_CHARS_DEF,
   localparam int IW = $clog2(MAX_OUT_CHARS),
   localparam int CW = $clog2(MAX_OUT_CHARS + 1)
) (
   input  logic clock,
   input  logic reset,
   input  lc3ie_pkg::push_type push,
   input  logic [IW-1:0] push_idx,
   input  lc3ie_pkg::fin_type fin,
   input  logic [CW-1:0] fin_count,
   output logic emit_busy,
   output logic rsp_strobe,
   output lc3ie_pkg::rsp_word_type rsp_word
);

   logic [7:0] buf_mem [MAX_OUT_CHARS];
   logic [7:0] buf_q;
   logic run_ff, run_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] total_ff, total_in;
   logic strobe_ff, strobe_in;
   logic last_ff, last_in;
   logic chars_ff, chars_in;
   logic halted_ff, halted_in;
   logic [15:0] pc_ff, pc_in;
   logic trunc_ff, trunc_in;
   logic [CW-1:0] ptr_next;

   assign emit_busy = run_ff || strobe_ff;
   assign ptr_next = ptr_ff + CW'(1);

   always_comb begin
      run_in = run_ff;
      ptr_in = ptr_ff;
      total_in = total_ff;
      strobe_in = 1'b0;
      last_in = last_ff;
      chars_in = chars_ff;
      halted_in = halted_ff;
      pc_in = pc_ff;
      trunc_in = trunc_ff;
      if (fin.valid) begin
         halted_in = fin.halted;
         pc_in = fin.pc;
         trunc_in = fin.trunc;
         total_in = fin_count;
         ptr_in = '0;
         if (fin_count == '0) begin
            strobe_in = 1'b1;
            last_in = 1'b1;
            chars_in = 1'b0;
         end else begin
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         strobe_in = 1'b1;
         chars_in = 1'b1;
         last_in = (ptr_next == total_ff);
         ptr_in = ptr_next;
         if (ptr_next == total_ff) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      total_ff <= total_in;
      last_ff <= last_in;
      chars_ff <= chars_in;
      halted_ff <= halted_in;
      pc_ff <= pc_in;
      trunc_ff <= trunc_in;
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         buf_mem[push_idx] <= push.ch;
      end
      buf_q <= buf_mem[ptr_ff[IW-1:0]];
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word.out_valid = chars_ff;
   assign rsp_word.out_char = chars_ff ? buf_q : 8'd0;
   assign rsp_word.last = last_ff;
   assign rsp_word.halted = halted_ff;
   assign rsp_word.pc_now = pc_ff;
   assign rsp_word.truncated = trunc_ff;

`ifndef SYNTHESIS
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.last |=> !rsp_strobe)
      else $error("result directly after the final one");
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      fin.valid |-> !emit_busy)
      else $error("completion while results still streaming");
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_word.out_valid |-> rsp_word.last)
      else $error("characterless result not final");
`endif

endmodule

// File: rtl/lc3_instruction_executor_core.sv
// Top level of the LC-3 instruction executor: front queue, execution engine, result stage.
// Depends on lc3ie_pkg, lc3ie_front, lc3ie_exec and lc3ie_emit.
//
//   Channel   Handshake           Payload                     Direction
//   request   start / busy        req_word (req_word_type)    in
//   result    rsp_strobe          rsp_word (rsp_word_type)    out
//
// A request word is taken at a rising edge with start high and busy low; busy rises only
// when the two-entry queue between the front end and the engine is full.
// A memory load, a start-PC word or a skipped step holds the engine through pop, completion
// and the result. An instruction adds fetch and execute, a further memory read for a load,
// an indirect address or a string word, and a further step for a store write, for the second
// half of GETC and IN, and for each PUTSP high byte; every memory access goes through the
// single registered port of the word memory. Characters stream at one per cycle, and the
// next pop follows the last result.
// Reset clears the queue, PC, flags, halt mark and registers; memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle under rsp_strobe.
module lc3_instruction_executor_core #(
   parameter int MEM_WORDS = lc3ie_pkg::MEM_WORDS_DEF,
   parameter int MAX_OUT_CHARS = lc3ie_pkg::MAX_OUT_CHARS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  lc3ie_pkg::req_word_type req_word,
   output logic rsp_strobe,
   output lc3ie_pkg::rsp_word_type rsp_word
);

   localparam int IW = $clog2(MAX_OUT_CHARS);
   localparam int CW = $clog2(MAX_OUT_CHARS + 1);

   // Queue head toward the engine.
   logic q_valid;
   lc3ie_pkg::item_type q_item;
   logic pop;

   // Character pushes and per-word completion toward the result stage.
   lc3ie_pkg::push_type push;
   logic [IW-1:0] push_idx;
   lc3ie_pkg::fin_type fin;
   logic [CW-1:0] fin_count;
   logic emit_busy;

   lc3ie_front u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .q_valid(q_valid),
      .q_item(q_item),
      .pop(pop)
   );

   // The engine waits for the result stage to drain before taking the next word,
   // since both share the character buffer.
   lc3ie_exec #(
      .MEM_WORDS(MEM_WORDS),
      .MAX_OUT_CHARS(MAX_OUT_CHARS)
   ) u_exec (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_item(q_item),
      .pop(pop),
      .emit_busy(emit_busy),
      .push(push),
      .push_idx(push_idx),
      .fin(fin),
      .fin_count(fin_count)
   );

   lc3ie_emit #(
      .MAX_OUT_CHARS(MAX_OUT_CHARS)
   ) u_emit (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_idx(push_idx),
      .fin(fin),
      .fin_count(fin_count),
      .emit_busy(emit_busy),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word)
   );

endmodule

// File: sim/lc3ie_checker.sv
// Result checker for the LC-3 instruction executor: watches both channels and predicts results.
// Depends on lc3ie_pkg for the word types, opcode, trap and flag codes.
module lc3ie_checker (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  lc3ie_pkg::req_word_type req_word,
   input  logic rsp_strobe,
   input  lc3ie_pkg::rsp_word_type rsp_word,
   output int fail_count,
   output int pending
);
   import lc3ie_pkg::*;

   bit [15:0] mem [0:65535];
   bit written [0:65535];
   bit [15:0] gpr [0:7];
   bit [15:0] pc_reg;
   bit [2:0] flags;
   bit halt_bit;

   bit key_rdy;
   bit [7:0] key_chr;
   bit [7:0] chars [$];
   bit trunc;

   // Trial runs keep memory writes aside and note the first unwritten word they touch.
   bit trial;
   bit [15:0] trial_mem [int];
   int miss_addr;

   rsp_word_type expected_q [$];

   function automatic void mem_put(bit [15:0] a, bit [15:0] v);
      if (trial) begin
         trial_mem[a] = v;
      end else begin
         mem[a] = v;
         written[a] = 1'b1;
      end
   endfunction

   function automatic bit [15:0] mem_get(bit [15:0] a);
      if (a == KBSR_ADDR) begin
         if (key_rdy) begin
            mem_put(KBSR_ADDR, KB_READY_WORD);
            mem_put(KBDR_ADDR, {8'h00, key_chr});
         end else begin
            mem_put(KBSR_ADDR, 16'h0000);
         end
      end
      if (trial && trial_mem.exists(a)) return trial_mem[a];
      if (!written[a]) begin
         if (miss_addr < 0) miss_addr = a;
         return 16'h0000;
      end
      return mem[a];
   endfunction

   function automatic void reg_put(bit [2:0] r, bit [15:0] v);
      gpr[r] = v;
      flags = (v == 16'h0000) ? FLAG_Z : (v[15] ? FLAG_N : FLAG_P);
   endfunction

   function automatic bit put_char(bit [7:0] c);
      if (chars.size() >= MAX_OUT_CHARS_DEF) begin
         trunc = 1'b1;
         return 1'b0;
      end
      chars.push_back(c);
      return 1'b1;
   endfunction

   function automatic void run_trap(bit [7:0] vec);
      bit [15:0] a;
      bit [15:0] w;
      gpr[7] = pc_reg;
      case (vec)
         TRAP_GETC: reg_put(3'd0, {8'h00, key_chr});
         TRAP_OUT: void'(put_char(gpr[0][7:0]));
         TRAP_PUTS: begin
            a = gpr[0];
            forever begin
               w = mem_get(a);
               if (w[7:0] == 8'h00 || !put_char(w[7:0])) break;
               a = a + 16'd1;
            end
         end
         TRAP_IN: begin
            void'(put_char(PROMPT_CHAR));
            reg_put(3'd0, {8'h00, key_chr});
            void'(put_char(key_chr));
         end
         TRAP_PUTSP: begin
            a = gpr[0];
            forever begin
               w = mem_get(a);
               if (w[7:0] == 8'h00 || !put_char(w[7:0])) break;
               if (w[15:8] == 8'h00 || !put_char(w[15:8])) break;
               a = a + 16'd1;
            end
         end
         TRAP_HALT: halt_bit = 1'b1;
         default: ;
      endcase
   endfunction

   function automatic void run_instruction();
      bit [15:0] ins;
      bit [2:0] dr;
      bit [2:0] sr1;
      bit [15:0] near_addr;
      bit [15:0] operand;
      bit [15:0] link;
      bit [15:0] offs6;
      ins = mem_get(pc_reg);
      dr = ins[11:9];
      sr1 = ins[8:6];
      pc_reg = pc_reg + 16'd1;
      near_addr = pc_reg + {{7{ins[8]}}, ins[8:0]};
      operand = ins[5] ? {{11{ins[4]}}, ins[4:0]} : gpr[ins[2:0]];
      offs6 = {{10{ins[5]}}, ins[5:0]};
      case (ins[15:12])
         OP_BR: if ((dr & flags) != 3'd0) pc_reg = near_addr;
         OP_ADD: reg_put(dr, gpr[sr1] + operand);
         OP_LD: reg_put(dr, mem_get(near_addr));
         OP_ST: mem_put(near_addr, gpr[dr]);
         OP_JSR: begin
            link = pc_reg;
            if (ins[11]) pc_reg = pc_reg + {{5{ins[10]}}, ins[10:0]};
            else pc_reg = gpr[sr1];
            gpr[7] = link;
         end
         OP_AND: reg_put(dr, gpr[sr1] & operand);
         OP_LDR: reg_put(dr, mem_get(gpr[sr1] + offs6));
         OP_STR: mem_put(gpr[sr1] + offs6, gpr[dr]);
         OP_NOT: reg_put(dr, ~gpr[sr1]);
         OP_LDI: reg_put(dr, mem_get(mem_get(near_addr)));
         OP_STI: mem_put(mem_get(near_addr), gpr[dr]);
         OP_JMP: pc_reg = gpr[sr1];
         OP_LEA: reg_put(dr, near_addr);
         OP_TRAP: run_trap(ins[7:0]);
         default: ;
      endcase
   endfunction

   function automatic void apply_word(req_word_type w);
      key_rdy = w.key_ready;
      key_chr = w.key_code;
      chars.delete();
      trunc = 1'b0;
      case (w.op)
         OPC_LOAD: mem_put(w.address, w.data);
         OPC_SETPC: begin
            pc_reg = w.address;
            halt_bit = 1'b0;
         end
         OPC_EXEC: if (!halt_bit) run_instruction();
         default: ;
      endcase
   endfunction

   // Dry run of one word: returns the first never-written address it would read, or -1.
   function automatic int first_miss(req_word_type w);
      bit [15:0] save_gpr [0:7];
      bit [15:0] save_pc;
      bit [2:0] save_flags;
      bit save_halt;
      save_gpr = gpr;
      save_pc = pc_reg;
      save_flags = flags;
      save_halt = halt_bit;
      trial = 1'b1;
      trial_mem.delete();
      miss_addr = -1;
      apply_word(w);
      trial = 1'b0;
      gpr = save_gpr;
      pc_reg = save_pc;
      flags = save_flags;
      halt_bit = save_halt;
      return miss_addr;
   endfunction

   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type r;
      int n;
      if (reset) begin
         foreach (gpr[i]) gpr[i] = 16'h0000;
         pc_reg = 16'h0000;
         flags = 3'd0;
         halt_bit = 1'b0;
         trial = 1'b0;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (start && !busy) begin
            apply_word(req_word);
            n = (chars.size() > 0) ? chars.size() : 1;
            for (int k = 0; k < n; k++) begin
               r.out_valid = chars.size() > 0;
               r.out_char = (chars.size() > 0) ? chars[k] : 8'h00;
               r.last = (k == n - 1);
               r.halted = halt_bit;
               r.pc_now = pc_reg;
               r.truncated = trunc;
               expected_q.push_back(r);
            end
         end
         if (rsp_strobe) begin
            if (expected_q.size() == 0) begin
               $error("result word arrived with nothing expected");
               fail_count++;
            end else begin
               r = expected_q.pop_front();
               check_field("out_valid", r.out_valid, rsp_word.out_valid);
               check_field("out_char", r.out_char, rsp_word.out_char);
               check_field("last", r.last, rsp_word.last);
               check_field("halted", r.halted, rsp_word.halted);
               check_field("pc_now", r.pc_now, rsp_word.pc_now);
               check_field("truncated", r.truncated, rsp_word.truncated);
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

// File: sim/tb.sv
// Top of the LC-3 executor testbench: clock, reset, stimulus and the final verdict.
// Depends on lc3ie_pkg, lc3_instruction_executor_core and lc3ie_checker.
module tb;
   import lc3ie_pkg::*;

   // Codes that the package leaves unnamed.
   localparam logic [1:0] OPC_UNUSED = 2'd3;
   localparam logic [3:0] OP_RTI = 4'd8;
   localparam logic [3:0] OP_RES = 4'd13;
   localparam logic [7:0] TRAP_OTHER = 8'h26;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TARGET_WORDS = 220;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_word_type req_word = '0;
   logic rsp_strobe;
   rsp_word_type rsp_word;
   int fail_count;
   int pending;

   int cycles = 0;
   int words_sent = 0;
   bit no_gaps = 1'b0;
   bit long_fill = 1'b0;

   lc3_instruction_executor_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   lc3ie_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending(pending)
   );

   always #4 clock = ~clock;

   // The run is cut off if it ever stalls; this far exceeds the slowest correct run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Drives one word from a falling edge and holds it until the block takes it.
   // Busy is read right after the rising edge, so it is the value the edge saw.
   // The task returns on the next falling edge with start still high.
   task automatic send(req_word_type w);
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      @(negedge clock);
      words_sent++;
   endtask

   // Random sender gap: mostly none or short, now and then long, and whole
   // stretches with none at all.
   task automatic gap();
      int g;
      g = $urandom_range(0, 9);
      if (no_gaps || g < 5) return;
      start <= 1'b0;
      if (g < 9) g = $urandom_range(1, 3);
      else g = $urandom_range(8, 30);
      repeat (g) @(negedge clock);
   endtask

   function automatic req_word_type make_word(logic [1:0] op, logic [15:0] a, logic [15:0] d,
                                              logic kr, logic [7:0] kc);
      req_word_type w;
      w.op = op;
      w.address = a;
      w.data = d;
      w.key_ready = kr;
      w.key_code = kc;
      return w;
   endfunction

   function automatic req_word_type any_word(logic [1:0] op, logic [15:0] a, logic [15:0] d);
      return make_word(op, a, d, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
   endfunction

   // String words: zero bytes now and then so strings end, never in long mode.
   function automatic logic [15:0] fill_data();
      logic [15:0] d;
      d = 16'($urandom_range(0, 65535));
      if (long_fill) begin
         if (d[7:0] == 8'h00) d[7:0] = 8'h41;
         if (d[15:8] == 8'h00) d[15:8] = 8'h42;
      end else begin
         if ($urandom_range(0, 4) == 0) d[7:0] = 8'h00;
         if ($urandom_range(0, 4) == 0) d[15:8] = 8'h00;
      end
      return d;
   endfunction

   // Places the instruction at the current PC, writes every word the step would
   // read that was never written, then executes it.
   task automatic run_ins(logic [15:0] ins, logic kr, logic [7:0] kc);
      req_word_type ex;
      int miss;
      send(any_word(OPC_LOAD, chk.pc_reg, ins));
      gap();
      ex = make_word(OPC_EXEC, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     kr, kc);
      forever begin
         miss = chk.first_miss(ex);
         if (miss < 0) break;
         send(any_word(OPC_LOAD, miss[15:0], fill_data()));
         gap();
      end
      send(ex);
      gap();
   endtask

   function automatic logic [15:0] rand_ins(logic [3:0] opc);
      logic [11:0] body;
      body = 12'($urandom_range(0, 4095));
      return {opc, body};
   endfunction

   function automatic logic [15:0] trap_ins(logic [7:0] vec);
      return {OP_TRAP, 4'h0, vec};
   endfunction

   function automatic logic [7:0] rand_trap();
      logic [7:0] v;
      v = TRAP_GETC + 8'($urandom_range(0, 6));
      return v;
   endfunction

   task automatic wait_drained();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      logic [3:0] opc;
      int pick;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: field extremes, the unused op, and every opcode but TRAP.
      send(make_word(OPC_LOAD, 16'h0000, 16'hFFFF, 1'b1, 8'hFF));
      send(make_word(OPC_LOAD, 16'hFFFF, 16'h0000, 1'b0, 8'h00));
      send(make_word(OPC_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF));
      send(make_word(OPC_SETPC, 16'h3000, 16'h0000, 1'b0, 8'h00));
      for (int k = 0; k < 16; k++) begin
         opc = 4'(k);
         if (opc != OP_TRAP) begin
            run_ins(rand_ins(opc), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end
      run_ins(rand_ins(OP_RTI), 1'b0, 8'h00);
      run_ins(rand_ins(OP_RES), 1'b0, 8'h00);
      // JSRR with R7 as the target register.
      run_ins({OP_JSR, 3'b000, 3'd7, 6'd0}, 1'b0, 8'h00);

      // Keyboard status read with and without a key, then the data register.
      send(make_word(OPC_SETPC, 16'hFDF0, 16'h0000, 1'b0, 8'h00));
      run_ins({OP_LD, 3'd1, 9'h00F}, 1'b1, 8'h5A);
      send(make_word(OPC_SETPC, 16'hFDF0, 16'h0000, 1'b0, 8'h00));
      run_ins({OP_LD, 3'd2, 9'h00F}, 1'b0, 8'h11);
      send(make_word(OPC_SETPC, 16'hFDF0, 16'h0000, 1'b0, 8'h00));
      run_ins({OP_LD, 3'd3, 9'h011}, 1'b1, 8'hA5);

      // All traps but HALT; GETC without a waiting key still takes the code.
      send(make_word(OPC_SETPC, 16'h4000, 16'h0000, 1'b0, 8'h00));
      run_ins(trap_ins(TRAP_GETC), 1'b0, 8'h80);
      run_ins(trap_ins(TRAP_OUT), 1'b0, 8'h00);
      run_ins(trap_ins(TRAP_IN), 1'b1, 8'h7F);
      run_ins(trap_ins(TRAP_PUTS), 1'b0, 8'h00);
      run_ins(trap_ins(TRAP_PUTSP), 1'b0, 8'h00);
      run_ins(trap_ins(TRAP_OTHER), 1'b0, 8'h00);

      // Hold the sender until everything so far has come back.
      wait_drained();
      run_ins(trap_ins(TRAP_HALT), 1'b0, 8'h00);
      send(make_word(OPC_EXEC, 16'h1234, 16'h5678, 1'b0, 8'h00));
      send(make_word(OPC_SETPC, 16'h5000, 16'h0000, 1'b0, 8'h00));

      // Random part: mostly instruction steps, some PC moves, raw loads and noise.
      while (words_sent < TARGET_WORDS) begin
         if ($urandom_range(0, 39) == 0) no_gaps = ~no_gaps;
         if ($urandom_range(0, 60) == 0) wait_drained();
         pick = $urandom_range(0, 99);
         long_fill = 1'b0;
         if (pick < 8) begin
            send(any_word(OPC_SETPC, 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535))));
            gap();
         end else if (pick < 11) begin
            send(any_word(OPC_UNUSED, 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535))));
            gap();
         end else if (pick < 15) begin
            send(any_word(OPC_LOAD, 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535))));
            gap();
         end else if (pick < 18) begin
            // A string long enough to hit the character bound.
            long_fill = 1'b1;
            run_ins(trap_ins($urandom_range(0, 1) ? TRAP_PUTS : TRAP_PUTSP), 1'b0, 8'h00);
         end else if (pick < 38) begin
            run_ins(trap_ins(rand_trap()), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)));
         end else begin
            opc = 4'($urandom_range(0, 14));
            run_ins(rand_ins(opc), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end

      wait_drained();
      repeat (300) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
